/* rtl/mtfo_pkg.sv */
// Shared types and constants for the metering trimmed filter with overcurrent guard.
// Used by mtfo_window, mtfo_divider and the top level; depends on nothing else.
`default_nettype none

package mtfo_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WIN_LEN    = 6;
    localparam int WIN_IDX_W  = 3;
    localparam int BIT_CNT_W  = $clog2(SAMPLE_W);

    // Every unordered pair of window entries, first index below second.
    localparam int PAIR_N = WIN_LEN * (WIN_LEN - 1) / 2;
    localparam logic [WIN_IDX_W-1:0] PAIR_A [PAIR_N] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4
    };
    localparam logic [WIN_IDX_W-1:0] PAIR_B [PAIR_N] = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3, 3'd4,
        3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5
    };

    localparam int MILLI      = 1000;
    localparam int AGREE_W    = 10;
    localparam int DIV_NUM_W  = SAMPLE_W + AGREE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
    localparam int CHECK_W    = DIV_NUM_W + 1;

    localparam int MARGIN_W   = 2;
    localparam int COUNT_W    = 5;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [SAMPLE_W-1:0] LIMIT_RESET  = 16'd16000;
    localparam logic [SAMPLE_W-1:0] ALARM_RESET  = 16'd15300;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 2'd2;
    localparam logic [COUNT_W-1:0]  NOTIFY_RESET = 5'd3;
    localparam logic [COUNT_W-1:0]  TRIP_RESET   = 5'd22;
    localparam logic [AGREE_W-1:0]  AGREE_RESET  = 10'd15;

    typedef enum logic [2:0] {
        REG_LIMIT  = 3'd0,
        REG_ALARM  = 3'd1,
        REG_MARGIN = 3'd2,
        REG_NOTIFY = 3'd3,
        REG_TRIP   = 3'd4,
        REG_AGREE  = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_EST,
        ST_CHECK,
        ST_STRIKE
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] power_sample;
        logic [SAMPLE_W-1:0] voltage_sample;
        logic [SAMPLE_W-1:0] current_sample;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] current_ma;
        logic [SAMPLE_W-1:0] voltage_dv;
        logic [SAMPLE_W-1:0] power_dw;
        logic                window_done;
        logic                notify_pulse;
        logic                trip_pulse;
    } out_item_t;

    typedef struct packed {
        logic                 wr_en;
        logic [WIN_IDX_W-1:0] slot;
        logic                 clr;
        logic                 cmp;
        logic                 sum;
    } win_ctrl_t;

endpackage

`default_nettype wire

/* rtl/mtfo_window.sv */
// Six-entry sample window with a bit-serial rank sort and a bit-serial trimmed mean.
// Depends on mtfo_pkg; driven by the control sequencer in the top level.
`default_nettype none

module mtfo_window
    import mtfo_pkg::*;
(
    input  logic                clk,
    input  win_ctrl_t           ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [SAMPLE_W-1:0] mean
);

    logic [SAMPLE_W-1:0]  win_reg [WIN_LEN];
    logic [PAIR_N-1:0]    dec_reg;
    logic [PAIR_N-1:0]    gt_reg;
    logic                 carry_reg;
    logic [SAMPLE_W-1:0]  acc_reg;

    logic [WIN_LEN-1:0]   msb_vec;
    logic [WIN_LEN-1:0]   lsb_vec;
    logic [WIN_IDX_W-1:0] rank [WIN_LEN];
    logic [WIN_LEN-1:0]   sel_lo;
    logic [WIN_LEN-1:0]   sel_hi;
    logic [1:0]           bit_sum;

    always_comb
    begin
        for (int k = 0; k < WIN_LEN; k++)
        begin
            msb_vec[k] = win_reg[k][SAMPLE_W-1];
            lsb_vec[k] = win_reg[k][0];
        end
    end

    // The rank of an entry counts the entries ahead of it in a stable ascending sort.
    always_comb
    begin
        for (int k = 0; k < WIN_LEN; k++)
        begin
            rank[k] = '0;
        end
        for (int p = 0; p < PAIR_N; p++)
        begin
            if (dec_reg[p] && gt_reg[p])
            begin
                rank[PAIR_A[p]] = rank[PAIR_A[p]] + 3'd1;
            end
            else
            begin
                rank[PAIR_B[p]] = rank[PAIR_B[p]] + 3'd1;
            end
        end
        for (int k = 0; k < WIN_LEN; k++)
        begin
            sel_lo[k] = (rank[k] == 3'd2);
            sel_hi[k] = (rank[k] == 3'd3);
        end
    end

    assign bit_sum = 2'(|(sel_lo & lsb_vec)) + 2'(|(sel_hi & lsb_vec)) + 2'(carry_reg);

    // The compare pass rotates MSB first, the sum pass rotates LSB first.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            win_reg[ctrl.slot] <= sample;
        end
        else if (ctrl.cmp)
        begin
            for (int k = 0; k < WIN_LEN; k++)
            begin
                win_reg[k] <= {win_reg[k][SAMPLE_W-2:0], win_reg[k][SAMPLE_W-1]};
            end
        end
        else if (ctrl.sum)
        begin
            for (int k = 0; k < WIN_LEN; k++)
            begin
                win_reg[k] <= {win_reg[k][0], win_reg[k][SAMPLE_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clr)
        begin
            dec_reg   <= '0;
            gt_reg    <= '0;
            carry_reg <= 1'b0;
        end
        else if (ctrl.cmp)
        begin
            for (int p = 0; p < PAIR_N; p++)
            begin
                if (!dec_reg[p] && (msb_vec[PAIR_A[p]] != msb_vec[PAIR_B[p]]))
                begin
                    dec_reg[p] <= 1'b1;
                    gt_reg[p]  <= msb_vec[PAIR_A[p]];
                end
            end
        end
        else if (ctrl.sum)
        begin
            carry_reg <= bit_sum[1];
            acc_reg   <= {bit_sum[0], acc_reg[SAMPLE_W-1:1]};
        end
    end

    // The final carry is bit 16 of the sum, so halving keeps it as the top bit.
    assign mean = {carry_reg, acc_reg[SAMPLE_W-1:1]};

endmodule

`default_nettype wire

/* rtl/mtfo_divider.sv */
// Restoring divider that retires one quotient bit per cycle.
// Depends on mtfo_pkg; started by the top level for the power over voltage estimate.
`default_nettype none

module mtfo_divider
    import mtfo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [SAMPLE_W-1:0]  den,
    output logic [DIV_NUM_W-1:0] quot,
    output logic                 done
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [SAMPLE_W-1:0]  rem_reg;
    logic [SAMPLE_W-1:0]  den_reg;

    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    trial_sub;
    logic                 trial_ge;
    logic [SAMPLE_W-1:0]  rem_next;
    logic [DIV_NUM_W-1:0] num_next;

    // A zero divisor makes every trial succeed, so the quotient comes out all ones.
    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        trial_ge  = (trial >= {1'b0, den_reg});
        rem_next  = trial_ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
        num_next  = {num_reg[DIV_NUM_W-2:0], trial_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            busy_reg <= (cnt_reg != CNT_LAST);
            done_reg <= (cnt_reg == CNT_LAST);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/meter_trimmed_filter_overcurrent.sv */
// Channel   Direction  Handshake              Beat contents
// in        input      in_valid / in_stall    in_item_t: power, voltage, current sample
// out       output     out_valid / out_stall  in order: current, voltage, power, flags
// apb       input      psel/penable, pready   six threshold and tolerance registers
//
// A sample that does not close a window goes from the idle state to the strike state,
// then into the output register. A sample that closes a window first passes through a
// bit-serial rank pass, a bit-serial sum pass and the 26-step divider.
// Reset clears the held values, strike counters and fill count; window entries start
// undefined. A stalled result stays in the output register while the next beat is taken.
//
// Top level: sequencer, cross-check, strike counters and register port.
// Depends on mtfo_pkg, mtfo_window and mtfo_divider.
`default_nettype none

module meter_trimmed_filter_overcurrent
    import mtfo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    localparam logic [WIN_IDX_W-1:0] SLOT_LAST = WIN_IDX_W'(WIN_LEN - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(SAMPLE_W - 1);

    state_t               state_reg;
    state_t               state_next;

    logic [SAMPLE_W-1:0]  limit_reg;
    logic [SAMPLE_W-1:0]  alarm_reg;
    logic [MARGIN_W-1:0]  margin_reg;
    logic [COUNT_W-1:0]   notify_cnt_reg;
    logic [COUNT_W-1:0]   trip_cnt_reg;
    logic [AGREE_W-1:0]   agree_reg;

    logic [WIN_IDX_W-1:0] fill_reg;
    logic                 win_done_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [SAMPLE_W-1:0]  held_current_reg;
    logic [SAMPLE_W-1:0]  held_voltage_reg;
    logic [SAMPLE_W-1:0]  held_power_reg;
    logic [SAMPLE_W-1:0]  prev_reg;
    logic [MARGIN_W-1:0]  limit_strikes_reg;
    logic [MARGIN_W-1:0]  limit_strikes_next;
    logic [COUNT_W-1:0]   alarm_strikes_reg;
    logic [COUNT_W-1:0]   alarm_strikes_next;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic [SAMPLE_W-1:0]  est_reg;
    logic [SAMPLE_W-1:0]  diff_reg;
    logic [DIV_NUM_W-1:0] tol_reg;

    logic                 in_acc;
    logic                 last_slot;
    logic                 bit_last;
    logic                 cfg_wr;
    cfg_reg_t             cfg_idx;
    win_ctrl_t            win_ctrl;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_NUM_W-1:0] div_quot;
    logic                 out_load;

    logic [SAMPLE_W-1:0]  mean_p;
    logic [SAMPLE_W-1:0]  mean_v;
    logic [SAMPLE_W-1:0]  mean_c;

    logic [SAMPLE_W-1:0]  est_next;
    logic [CHECK_W-1:0]   tol_limit;
    logic                 agree_ok;
    logic [SAMPLE_W:0]    avg_sum;
    logic [SAMPLE_W-1:0]  check_res;

    logic [MARGIN_W:0]    lim_inc;
    logic [COUNT_W:0]     alarm_inc;
    logic                 notify;
    logic                 trip;
    logic [SAMPLE_W-1:0]  cur_after;

    assign in_acc    = in_valid && !in_stall;
    assign last_slot = (fill_reg == SLOT_LAST);
    assign bit_last  = (bit_cnt_reg == BIT_LAST);

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_LIMIT:  prdata = CFG_DATA_W'(limit_reg);
            REG_ALARM:  prdata = CFG_DATA_W'(alarm_reg);
            REG_MARGIN: prdata = CFG_DATA_W'(margin_reg);
            REG_NOTIFY: prdata = CFG_DATA_W'(notify_cnt_reg);
            REG_TRIP:   prdata = CFG_DATA_W'(trip_cnt_reg);
            REG_AGREE:  prdata = CFG_DATA_W'(agree_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            alarm_reg      <= ALARM_RESET;
            margin_reg     <= MARGIN_RESET;
            notify_cnt_reg <= NOTIFY_RESET;
            trip_cnt_reg   <= TRIP_RESET;
            agree_reg      <= AGREE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LIMIT:  limit_reg      <= pwdata[SAMPLE_W-1:0];
                REG_ALARM:  alarm_reg      <= pwdata[SAMPLE_W-1:0];
                REG_MARGIN: margin_reg     <= pwdata[MARGIN_W-1:0];
                REG_NOTIFY: notify_cnt_reg <= pwdata[COUNT_W-1:0];
                REG_TRIP:   trip_cnt_reg   <= pwdata[COUNT_W-1:0];
                REG_AGREE:  agree_reg      <= pwdata[AGREE_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = last_slot ? ST_CMP : ST_STRIKE;
                end
            end
            ST_CMP:
            begin
                if (bit_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (bit_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EST;
                end
            end
            ST_EST:   state_next = ST_CHECK;
            ST_CHECK: state_next = ST_STRIKE;
            ST_STRIKE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        win_ctrl  = '0;
        div_start = 1'b0;
        in_stall  = 1'b1;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                win_ctrl.wr_en = in_valid;
                win_ctrl.slot  = fill_reg;
                win_ctrl.clr   = in_valid && last_slot;
            end
            ST_CMP:    win_ctrl.cmp = 1'b1;
            ST_SUM:    win_ctrl.sum = 1'b1;
            ST_MUL:    div_start = 1'b1;
            ST_STRIKE: out_load = !out_valid_reg || !out_stall;
            default:   ;
        endcase
    end

    // ---------------- windows and divider ----------------
    mtfo_window u_power_win (
        .clk    (clk),
        .ctrl   (win_ctrl),
        .sample (in_data.power_sample),
        .mean   (mean_p)
    );

    mtfo_window u_voltage_win (
        .clk    (clk),
        .ctrl   (win_ctrl),
        .sample (in_data.voltage_sample),
        .mean   (mean_v)
    );

    mtfo_window u_current_win (
        .clk    (clk),
        .ctrl   (win_ctrl),
        .sample (in_data.current_sample),
        .mean   (mean_c)
    );

    assign div_num = DIV_NUM_W'(mean_p) * DIV_NUM_W'(MILLI);

    mtfo_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (mean_v),
        .quot  (div_quot),
        .done  (div_done)
    );

    // ---------------- cross-check ----------------
    always_comb
    begin
        if ((mean_v == '0) || (div_quot[DIV_NUM_W-1:SAMPLE_W] != '0))
        begin
            est_next = '1;
        end
        else
        begin
            est_next = div_quot[SAMPLE_W-1:0];
        end
    end

    // diff < floor(tol / 1000) holds exactly when (diff + 1) * 1000 <= tol.
    always_comb
    begin
        tol_limit = CHECK_W'({1'b0, diff_reg} + 17'd1) * CHECK_W'(MILLI);
        agree_ok  = (CHECK_W'(tol_reg) >= tol_limit);
        avg_sum   = {1'b0, mean_c} + {1'b0, prev_reg};
        if (held_power_reg == '0)
        begin
            check_res = mean_c;
        end
        else if (agree_ok)
        begin
            check_res = avg_sum[SAMPLE_W:1];
        end
        else
        begin
            check_res = est_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && div_done)
        begin
            est_reg <= est_next;
        end
        if (state_reg == ST_EST)
        begin
            diff_reg <= (est_reg >= mean_c) ? (est_reg - mean_c) : (mean_c - est_reg);
            tol_reg  <= DIV_NUM_W'(est_reg) * DIV_NUM_W'(agree_reg);
        end
    end

    // ---------------- strike counters ----------------
    always_comb
    begin
        lim_inc            = {1'b0, limit_strikes_reg} + 3'd1;
        alarm_inc          = {1'b0, alarm_strikes_reg} + 6'd1;
        notify             = 1'b0;
        trip               = 1'b0;
        cur_after          = held_current_reg;
        limit_strikes_next = limit_strikes_reg;
        alarm_strikes_next = alarm_strikes_reg;
        if (held_current_reg >= limit_reg)
        begin
            if (lim_inc > {1'b0, margin_reg})
            begin
                notify             = 1'b1;
                trip               = 1'b1;
                cur_after          = '0;
                limit_strikes_next = '0;
            end
            else
            begin
                limit_strikes_next = lim_inc[MARGIN_W-1:0];
            end
        end
        else if (held_current_reg >= alarm_reg)
        begin
            // The notify tick skips the trip check.
            if (alarm_inc == {1'b0, notify_cnt_reg})
            begin
                notify             = 1'b1;
                alarm_strikes_next = alarm_inc[COUNT_W-1:0];
            end
            else if (alarm_inc > {1'b0, trip_cnt_reg})
            begin
                trip               = 1'b1;
                cur_after          = '0;
                alarm_strikes_next = '0;
            end
            else
            begin
                alarm_strikes_next = alarm_inc[COUNT_W-1:0];
            end
        end
        else
        begin
            limit_strikes_next = '0;
            alarm_strikes_next = '0;
        end
    end

    // ---------------- state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            fill_reg          <= '0;
            win_done_reg      <= 1'b0;
            bit_cnt_reg       <= '0;
            held_current_reg  <= '0;
            held_voltage_reg  <= '0;
            held_power_reg    <= '0;
            prev_reg          <= '0;
            limit_strikes_reg <= '0;
            alarm_strikes_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc)
            begin
                fill_reg     <= last_slot ? '0 : fill_reg + 1'b1;
                win_done_reg <= last_slot;
            end

            if (state_reg == ST_CMP || state_reg == ST_SUM)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            else
            begin
                bit_cnt_reg <= '0;
            end

            if (state_reg == ST_MUL)
            begin
                held_power_reg   <= mean_p;
                held_voltage_reg <= mean_v;
            end

            if (state_reg == ST_CHECK)
            begin
                held_current_reg <= check_res;
                prev_reg         <= check_res;
            end
            else if (out_load)
            begin
                held_current_reg <= cur_after;
            end

            if (out_load)
            begin
                limit_strikes_reg <= limit_strikes_next;
                alarm_strikes_reg <= alarm_strikes_next;
                out_valid_reg     <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.current_ma   <= cur_after;
            out_reg.voltage_dv   <= held_voltage_reg;
            out_reg.power_dw     <= held_power_reg;
            out_reg.window_done  <= win_done_reg;
            out_reg.notify_pulse <= notify;
            out_reg.trip_pulse   <= trip;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- assertions ----------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOT_LAST)
        else $error("window fill count out of range");

    a_trip_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.trip_pulse) |-> (out_data.current_ma == '0))
        else $error("trip beat carries a nonzero current");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    a_window_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && win_done_reg) |-> (fill_reg == '0))
        else $error("window completed without the fill count wrapping");

endmodule

`default_nettype wire

/* tb/tb_meter_trimmed_filter_overcurrent.sv */
// Self-checking testbench for meter_trimmed_filter_overcurrent: trimmed window means,
// the power-over-voltage current cross-check and the strike counters, over several
// register settings. Depends on mtfo_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_meter_trimmed_filter_overcurrent;
    import mtfo_pkg::*;

    localparam int EST_MAX        = 65535;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_WINDOWS  = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    meter_trimmed_filter_overcurrent u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Register copies used by the predictor.
    logic [SAMPLE_W-1:0] lim_ma    = LIMIT_RESET;
    logic [SAMPLE_W-1:0] alm_ma    = ALARM_RESET;
    logic [MARGIN_W-1:0] margin    = MARGIN_RESET;
    logic [COUNT_W-1:0]  notify_at = NOTIFY_RESET;
    logic [COUNT_W-1:0]  trip_over = TRIP_RESET;
    logic [AGREE_W-1:0]  agree_pm  = AGREE_RESET;

    // Filter state mirrored by the predictor.
    logic [WIN_LEN-1:0][SAMPLE_W-1:0] pwr_win  = '0;
    logic [WIN_LEN-1:0][SAMPLE_W-1:0] volt_win = '0;
    logic [WIN_LEN-1:0][SAMPLE_W-1:0] cur_win  = '0;
    int                  fill_cnt    = 0;
    logic [SAMPLE_W-1:0] held_cur    = '0;
    logic [SAMPLE_W-1:0] held_volt   = '0;
    logic [SAMPLE_W-1:0] held_pow    = '0;
    logic [SAMPLE_W-1:0] prev_cur    = '0;
    logic [MARGIN_W-1:0] limit_strk  = '0;
    logic [COUNT_W-1:0]  alarm_strk  = '0;

    in_item_t  sample_q[$];
    out_item_t expected_readings[$];
    out_item_t seen_want;

    int idle_pct     = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int n_samples    = 0;
    int n_checked    = 0;
    int n_windows    = 0;
    int n_trips      = 0;
    int n_notifies   = 0;
    int n_settings   = 0;
    int run_left     = 0;
    int run_cur      = 0;
    int run_volt     = 2300;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [SAMPLE_W-1:0] clip16(input int x);
        if (x < 0)
            return '0;
        if (x > EST_MAX)
            return SAMPLE_W'(EST_MAX);
        return SAMPLE_W'(x);
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mean of the two middle values of a sorted window, rounded down.
    function automatic logic [SAMPLE_W-1:0] trimmed_mean(
        input logic [WIN_LEN-1:0][SAMPLE_W-1:0] w);
        logic [WIN_LEN-1:0][SAMPLE_W-1:0] srt;
        logic [SAMPLE_W-1:0] t;
        int i, j;
        srt = w;
        for (i = 1; i < WIN_LEN; i++)
            for (j = i; j > 0 && srt[j-1] > srt[j]; j--)
            begin
                t = srt[j-1];
                srt[j-1] = srt[j];
                srt[j] = t;
            end
        return SAMPLE_W'((17'(srt[2]) + 17'(srt[3])) >> 1);
    endfunction

    function automatic logic [SAMPLE_W-1:0] cross_checked(
        input logic [SAMPLE_W-1:0] cur, input logic [SAMPLE_W-1:0] vol,
        input logic [SAMPLE_W-1:0] pwr);
        int unsigned est, diff, tol;
        if (pwr == 0)
            return cur;
        if (vol == 0)
            est = EST_MAX;
        else
        begin
            est = (32'(pwr) * MILLI) / 32'(vol);
            if (est > EST_MAX)
                est = EST_MAX;
        end
        diff = (est > cur) ? est - cur : 32'(cur) - est;
        tol = (est * 32'(agree_pm)) / MILLI;
        if (diff < tol)
            return SAMPLE_W'((32'(cur) + 32'(prev_cur)) >> 1);
        return SAMPLE_W'(est);
    endfunction

    task automatic predict_reading(input in_item_t s);
        out_item_t   r;
        int unsigned nxt;
        r = '0;
        pwr_win[fill_cnt]  = s.power_sample;
        volt_win[fill_cnt] = s.voltage_sample;
        cur_win[fill_cnt]  = s.current_sample;
        fill_cnt++;
        if (fill_cnt == WIN_LEN)
        begin
            held_pow  = trimmed_mean(pwr_win);
            held_volt = trimmed_mean(volt_win);
            held_cur  = cross_checked(trimmed_mean(cur_win), held_volt, held_pow);
            prev_cur  = held_cur;
            fill_cnt  = 0;
            r.window_done = 1'b1;
            n_windows++;
        end
        if (held_cur >= lim_ma)
        begin
            nxt = 32'(limit_strk) + 1;
            if (nxt > margin)
            begin
                r.notify_pulse = 1'b1;
                r.trip_pulse   = 1'b1;
                held_cur       = '0;
                limit_strk     = '0;
            end
            else
                limit_strk = MARGIN_W'(nxt);
        end
        else if (held_cur >= alm_ma)
        begin
            nxt = 32'(alarm_strk) + 1;
            // A notify tick skips the trip test.
            if (nxt == notify_at)
            begin
                r.notify_pulse = 1'b1;
                alarm_strk     = COUNT_W'(nxt);
            end
            else if (nxt > trip_over)
            begin
                r.trip_pulse = 1'b1;
                held_cur     = '0;
                alarm_strk   = '0;
            end
            else
                alarm_strk = COUNT_W'(nxt);
        end
        else
        begin
            limit_strk = '0;
            alarm_strk = '0;
        end
        r.current_ma = held_cur;
        r.voltage_dv = held_volt;
        r.power_dw   = held_pow;
        n_trips    += r.trip_pulse;
        n_notifies += r.notify_pulse;
        n_samples++;
        expected_readings.push_back(r);
    endtask

    // Sample driver: one new beat per acceptance, with random gaps in bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_reading(in_data);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                begin
                    send_gap = $urandom_range(0, 12);
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    in_data  <= sample_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, also in bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch at result %0d, %s: expected %0d, got %0d",
                         n_checked, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: current %0d voltage %0d power %0d",
                             out_data.current_ma, out_data.voltage_dv, out_data.power_dw);
            end
            else
            begin
                seen_want = expected_readings.pop_front();
                check_field("current_ma", seen_want.current_ma, out_data.current_ma);
                check_field("voltage_dv", seen_want.voltage_dv, out_data.voltage_dv);
                check_field("power_dw", seen_want.power_dw, out_data.power_dw);
                check_field("window_done", seen_want.window_done, out_data.window_done);
                check_field("notify_pulse", seen_want.notify_pulse, out_data.notify_pulse);
                check_field("trip_pulse", seen_want.trip_pulse, out_data.trip_pulse);
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_readings.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LIMIT:  lim_ma    = val[SAMPLE_W-1:0];
            REG_ALARM:  alm_ma    = val[SAMPLE_W-1:0];
            REG_MARGIN: margin    = val[MARGIN_W-1:0];
            REG_NOTIFY: notify_at = val[COUNT_W-1:0];
            REG_TRIP:   trip_over = val[COUNT_W-1:0];
            REG_AGREE:  agree_pm  = val[AGREE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int lim, input int alm, input int mrg,
                                  input int ntf, input int trp, input int agr);
        cfg_write(REG_LIMIT, lim);
        cfg_write(REG_ALARM, alm);
        cfg_write(REG_MARGIN, mrg);
        cfg_write(REG_NOTIFY, ntf);
        cfg_write(REG_TRIP, trp);
        cfg_write(REG_AGREE, agr);
        n_settings++;
    endtask

    // Holds until every queued sample is taken and every result is back.
    task automatic drain_to_idle();
        @(negedge clk);
        while (sample_q.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_sample(input int p, input int v, input int c);
        in_item_t s;
        s.power_sample   = clip16(p);
        s.voltage_sample = clip16(v);
        s.current_sample = clip16(c);
        sample_q.push_back(s);
    endtask

    // One window of six samples. Most windows hold a steady load whose current often
    // sits near a threshold, so the strike counters get long runs to work on.
    task automatic push_window();
        int sel, pick, k, p, v, c;
        sel = $urandom_range(0, 99);
        if (run_left == 0)
        begin
            run_left = $urandom_range(1, 6);
            run_volt = $urandom_range(1800, 2600);
            pick = $urandom_range(0, 9);
            if (pick < 3)
                run_cur = int'(lim_ma) + jitter(200);
            else if (pick < 6)
                run_cur = int'(alm_ma) + jitter(200);
            else if (pick < 8)
                run_cur = $urandom_range(0, alm_ma);
            else
                run_cur = $urandom_range(0, EST_MAX);
            run_cur = clip16(run_cur);
        end
        run_left--;
        for (k = 0; k < WIN_LEN; k++)
        begin
            if (sel < 60)
            begin
                v = run_volt + jitter(5);
                c = run_cur + jitter(20);
                p = run_cur * run_volt / MILLI + jitter(3);
            end
            else if (sel < 72)
            begin
                p = 0;
                v = $urandom_range(0, EST_MAX);
                c = run_cur + jitter(20);
            end
            else if (sel < 80)
            begin
                p = $urandom_range(1, EST_MAX);
                v = 0;
                c = $urandom_range(0, EST_MAX);
            end
            else if (sel < 88)
            begin
                p = $urandom_range(30000, EST_MAX);
                v = $urandom_range(1, 400);
                c = $urandom_range(0, EST_MAX);
            end
            else
            begin
                p = $urandom_range(0, EST_MAX);
                v = $urandom_range(0, EST_MAX);
                c = $urandom_range(0, EST_MAX);
            end
            // An occasional outlier in one field; the trimming should drop it.
            if ($urandom_range(0, 19) == 0)
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    p = $urandom_range(0, EST_MAX);
                else if (pick == 1)
                    v = $urandom_range(0, EST_MAX);
                else
                    c = $urandom_range(0, EST_MAX);
            end
            push_sample(p, v, c);
        end
    endtask

    task automatic run_phase(input int pct);
        int w;
        idle_pct = pct;
        for (w = 0; w < PHASE_WINDOWS; w++)
            push_window();
    endtask

    task automatic random_settings();
        int lim;
        lim = $urandom_range(8000, 30000);
        apply_settings(lim, clip16(lim - int'($urandom_range(0, 3000))),
                       $urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, 60));
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 20;

        // Field extremes: zero voltage saturates the estimate and the limit trips.
        push_sample(65535, 0, 0);
        push_sample(65535, 0, 65535);
        push_sample(0, 65535, 0);
        push_sample(65535, 0, 65535);
        push_sample(65535, 0, 0);
        push_sample(0, 65535, 65535);
        // Zero power passes the current through; it sits in the alarm band.
        for (k = 0; k < WIN_LEN; k++)
            push_sample(0, 2300, 15800 - 100 * k);
        // Current agrees with power over voltage, so it is averaged with the last one.
        for (k = 0; k < WIN_LEN; k++)
            push_sample(35650, 2300, 15500 + ((k % 2 == 0) ? 40 : -40));
        // Disagreement: the estimate wins, despite voltage outliers at both ends.
        push_sample(11500, 65535, 10000);
        push_sample(11500, 2300, 9990);
        push_sample(11500, 0, 10010);
        push_sample(11500, 2300, 10000);
        push_sample(11500, 2300, 10020);
        push_sample(11500, 2300, 9980);

        drain_to_idle();
        apply_settings(65535, 0, 0, 1, 1, 0);
        run_phase(30);
        drain_to_idle();
        apply_settings(0, 65535, 3, 0, 31, 1023);
        run_phase(15);
        drain_to_idle();
        apply_settings(16000, 15300, 2, 3, 22, 15);
        run_phase(0);
        drain_to_idle();
        random_settings();
        run_phase(40);
        drain_to_idle();
        random_settings();
        run_phase(25);
        drain_to_idle();
        random_settings();
        run_phase(0);

        drain_to_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d samples, %0d completed windows, %0d register settings.",
                 n_samples, n_windows, n_settings + 1);
        $display("Checked %0d results with %0d trips and %0d notifications; %0d mismatches.",
                 n_checked, n_trips, n_notifies, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
